[design/rbtu_pkg.sv]
// Shared widths, stage record types and calendar helpers for the RTC-to-Unix-seconds converter.
package rbtu_pkg;

    localparam int RegW  = 8;
    localparam int SecW  = 7;
    localparam int MinW  = 7;
    localparam int HourW = 6;
    localparam int DayW  = 6;
    localparam int MonW  = 5;
    localparam int MpW   = 4;
    localparam int YpW   = 10;
    localparam int DoyW  = 9;
    localparam int Y365W = 18;
    localparam int TodW  = 17;
    localparam int DaysW = 17;
    localparam int SumW  = 19;
    localparam int UnixW = 34;

    // Register masks and flag bits
    localparam logic [RegW-1:0] MASK_7F    = 8'h7F;
    localparam logic [RegW-1:0] MASK_3F    = 8'h3F;
    localparam logic [RegW-1:0] MASK_1F    = 8'h1F;
    localparam int              BIT_12H    = 6;
    localparam int              BIT_PM     = 5;
    localparam int              BIT_CENT   = 7;

    // Year is carried as (year - 1600), shifted down by one for Jan/Feb.
    localparam logic [YpW-1:0]  YP_BASE    = 10'd400;
    localparam logic [YpW-1:0]  YP_CENTURY = 10'd100;

    // 365*y' + y'/4 - y'/100 + y'/400 + doy - DAY_OFS gives days since 1970-01-01
    localparam logic [SumW-1:0] DAY_OFS    = 19'd135080;
    localparam logic [TodW-1:0] SECS_HOUR  = 17'd3600;
    localparam logic [TodW-1:0] SECS_MIN   = 17'd60;
    localparam logic [DaysW-1:0] SECS_DAY  = 17'd86400;

    typedef struct packed {
        logic [SecW-1:0]  sec;
        logic [MinW-1:0]  min;
        logic [HourW-1:0] hour;
        logic [DayW-1:0]  day;
        logic [MpW-1:0]   mp;
        logic [YpW-1:0]   yp;
        logic             invalid;
    } t_dec;

    typedef struct packed {
        logic [DaysW-1:0] days;
        logic [TodW-1:0]  tod;
        logic             invalid;
    } t_days;

    // Tens nibble times ten plus units nibble; non-BCD nibbles just add in.
    function automatic logic [RegW-1:0] bcd_dec(logic [RegW-1:0] v);
        logic [RegW-1:0] tens;
        logic [RegW-1:0] units;
        tens  = {4'b0000, v[7:4]};
        units = {4'b0000, v[3:0]};
        return tens * 8'd10 + units;
    endfunction

    // Day of year for a March-based month index.
    function automatic logic [DoyW-1:0] month_start(logic [MpW-1:0] mp);
        logic [DoyW-1:0] d;
        case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

[design/rbtu_decode.sv]
// Stage 1: BCD decode, hour mode handling, range check and year/month remap.
module rbtu_decode import rbtu_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  logic [RegW-1:0] i_seconds_reg,
    input  logic [RegW-1:0] i_minutes_reg,
    input  logic [RegW-1:0] i_hours_reg,
    input  logic [RegW-1:0] i_date_reg,
    input  logic [RegW-1:0] i_month_reg,
    input  logic [RegW-1:0] i_year_reg,
    output logic            o_valid,
    output t_dec            o_data
);

    logic            r_valid;
    t_dec            r_data;
    t_dec            n_data;
    logic [RegW-1:0] sec_full;
    logic [RegW-1:0] min_full;
    logic [RegW-1:0] h12_full;
    logic [RegW-1:0] h24_full;
    logic [RegW-1:0] day_full;
    logic [RegW-1:0] mon_full;
    logic [RegW-1:0] yr_full;
    logic [HourW-1:0] hour;
    logic            pm;
    logic            jan_feb;

    always_comb begin
        sec_full = bcd_dec(i_seconds_reg & MASK_7F);
        min_full = bcd_dec(i_minutes_reg & MASK_7F);
        h12_full = bcd_dec(i_hours_reg & MASK_1F);
        h24_full = bcd_dec(i_hours_reg & MASK_3F);
        day_full = bcd_dec(i_date_reg & MASK_3F);
        mon_full = bcd_dec(i_month_reg & MASK_1F);
        yr_full  = bcd_dec(i_year_reg);
        pm       = i_hours_reg[BIT_PM];

        if (i_hours_reg[BIT_12H]) begin
            // 12 AM maps to 0, 12 PM stays 12
            if (h12_full == 8'd12) begin
                hour = pm ? 6'd12 : 6'd0;
            end else begin
                hour = h12_full[HourW-1:0] + (pm ? 6'd12 : 6'd0);
            end
        end else begin
            hour = h24_full[HourW-1:0];
        end

        jan_feb = (mon_full <= 8'd2);

        n_data.sec  = sec_full[SecW-1:0];
        n_data.min  = min_full[MinW-1:0];
        n_data.hour = hour;
        n_data.day  = day_full[DayW-1:0];
        n_data.mp   = jan_feb ? (mon_full[MpW-1:0] + 4'd9) : (mon_full[MpW-1:0] - 4'd3);
        n_data.yp   = YP_BASE + {2'b00, yr_full}
                    + (i_month_reg[BIT_CENT] ? YP_CENTURY : '0)
                    - {{(YpW-1){1'b0}}, jan_feb};
        n_data.invalid = (sec_full > 8'd59) || (min_full > 8'd59) || (hour > 6'd23)
                      || (day_full < 8'd1) || (day_full > 8'd31)
                      || (mon_full < 8'd1) || (mon_full > 8'd12);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    a_fields_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_data.invalid) |->
            (r_data.hour <= 6'd23 && r_data.mp <= 4'd11 && r_data.day >= 6'd1))
        else $error("decoded item marked valid with a field out of range");

endmodule

[design/rbtu_days.sv]
// Stages 2 and 3: year/day partial terms and time of day, then the day count sum.
module rbtu_days import rbtu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_valid,
    input  t_dec  i_data,
    output logic  o_valid,
    output t_days o_data
);

    logic              r_valid2;
    logic              r_valid3;
    logic [Y365W-1:0]  r_y365;
    logic [7:0]        r_q4;
    logic [2:0]        r_q100;
    logic              r_q400;
    logic [DoyW-1:0]   r_doy;
    logic [TodW-1:0]   r_tod2;
    logic              r_inv2;
    t_days             r_data;

    logic [Y365W-1:0]  n_y365;
    logic [2:0]        n_q100;
    logic [DoyW-1:0]   n_doy;
    logic [TodW-1:0]   n_tod;
    logic [SumW-1:0]   sum;

    always_comb begin
        n_y365 = {{(Y365W-YpW){1'b0}}, i_data.yp} * 18'd365;
        // y' stays within 399..665, so y'/100 is one of four values
        if (i_data.yp >= 10'd600) begin
            n_q100 = 3'd6;
        end else if (i_data.yp >= 10'd500) begin
            n_q100 = 3'd5;
        end else if (i_data.yp >= 10'd400) begin
            n_q100 = 3'd4;
        end else begin
            n_q100 = 3'd3;
        end
        n_doy = month_start(i_data.mp) + {{(DoyW-DayW){1'b0}}, i_data.day} - 9'd1;
        n_tod = {{(TodW-HourW){1'b0}}, i_data.hour} * SECS_HOUR
              + {{(TodW-MinW){1'b0}}, i_data.min} * SECS_MIN
              + {{(TodW-SecW){1'b0}}, i_data.sec};
    end

    always_comb begin
        sum = {{(SumW-Y365W){1'b0}}, r_y365}
            + {{(SumW-8){1'b0}}, r_q4}
            - {{(SumW-3){1'b0}}, r_q100}
            + {{(SumW-1){1'b0}}, r_q400}
            + {{(SumW-DoyW){1'b0}}, r_doy}
            - DAY_OFS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else if (i_adv) begin
            r_valid2 <= i_valid;
            r_valid3 <= r_valid2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_y365       <= n_y365;
            r_q4         <= i_data.yp[YpW-1:2];
            r_q100       <= n_q100;
            r_q400       <= (i_data.yp >= 10'd400);
            r_doy        <= n_doy;
            r_tod2       <= n_tod;
            r_inv2       <= i_data.invalid;
            r_data.days    <= sum[DaysW-1:0];
            r_data.tod     <= r_tod2;
            r_data.invalid <= r_inv2;
        end
    end

    assign o_valid = r_valid3;
    assign o_data  = r_data;

    a_days_after_2000: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid3 && !r_data.invalid) |-> (r_data.days >= 17'd10957))
        else $error("day count falls before 2000-01-01");

    a_tod_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid3 && !r_data.invalid) |-> (r_data.tod < 17'd86400))
        else $error("time of day exceeds one day");

endmodule

[design/rtc_bcd_time_to_unix_seconds_top.sv]
// Top level: RTC register set to Unix seconds, four-stage pipeline with output register.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   input   | i_in_valid / o_in_ready, six *_reg bytes  | in
//   output  | o_out_valid / i_out_ready, seconds, flag  | out
//
// One item is taken per cycle while the output is not stalled.
// The stages are decode, partial terms, day sum, and the days*86400 multiply.
// A stall on the output freezes every stage together, so nothing is lost or repeated;
// the input is taken whenever the final stage is empty or being drained.
// Reset is synchronous, active low, and clears the stage valid bits.
module rtc_bcd_time_to_unix_seconds_top import rbtu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [RegW-1:0]  i_seconds_reg,
    input  logic [RegW-1:0]  i_minutes_reg,
    input  logic [RegW-1:0]  i_hours_reg,
    input  logic [RegW-1:0]  i_date_reg,
    input  logic [RegW-1:0]  i_month_reg,
    input  logic [RegW-1:0]  i_year_reg,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [UnixW-1:0] o_epoch_secs,
    output logic             o_invalid
);

    logic             adv;
    logic             dec_valid;
    t_dec             dec_data;
    logic             days_valid;
    t_days            days_data;
    logic             r_out_valid;
    logic [UnixW-1:0] r_unix;
    logic             r_inv;
    logic [UnixW-1:0] n_unix;

    assign adv = !r_out_valid || i_out_ready;

    rbtu_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_valid       (i_in_valid),
        .i_seconds_reg (i_seconds_reg),
        .i_minutes_reg (i_minutes_reg),
        .i_hours_reg   (i_hours_reg),
        .i_date_reg    (i_date_reg),
        .i_month_reg   (i_month_reg),
        .i_year_reg    (i_year_reg),
        .o_valid       (dec_valid),
        .o_data        (dec_data)
    );

    rbtu_days u_days (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (dec_valid),
        .i_data  (dec_data),
        .o_valid (days_valid),
        .o_data  (days_data)
    );

    always_comb begin
        if (days_data.invalid) begin
            n_unix = '0;
        end else begin
            n_unix = {{(UnixW-DaysW){1'b0}}, days_data.days}
                   * {{(UnixW-DaysW){1'b0}}, SECS_DAY}
                   + {{(UnixW-TodW){1'b0}}, days_data.tod};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= days_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_unix <= n_unix;
            r_inv  <= days_data.invalid;
        end
    end

    assign o_in_ready     = adv;
    assign o_out_valid    = r_out_valid;
    assign o_epoch_secs   = r_unix;
    assign o_invalid      = r_inv;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_inv) |-> (r_unix == '0))
        else $error("invalid result carries nonzero seconds");

    a_valid_after_2000: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_inv) |-> (r_unix >= 34'd946684800))
        else $error("valid result lies before 2000-01-01");

endmodule

[bench/tb_rtc_bcd_time_to_unix_seconds_top.sv]
// Testbench for the RTC register set to Unix seconds converter: directed, random and backpressure traffic.
module tb_rtc_bcd_time_to_unix_seconds_top import rbtu_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD     = 300;
    localparam int SHOWN_ERRORS  = 10;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct packed {
        logic [RegW-1:0] sec_r;
        logic [RegW-1:0] min_r;
        logic [RegW-1:0] hour_r;
        logic [RegW-1:0] date_r;
        logic [RegW-1:0] month_r;
        logic [RegW-1:0] year_r;
    } t_rtc_regs;

    typedef struct packed {
        t_rtc_regs        regs;
        logic [UnixW-1:0] seconds;
        logic             invalid;
    } t_epoch;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [RegW-1:0]  seconds_reg = '0;
    logic [RegW-1:0]  minutes_reg = '0;
    logic [RegW-1:0]  hours_reg = '0;
    logic [RegW-1:0]  date_reg = '0;
    logic [RegW-1:0]  month_reg = '0;
    logic [RegW-1:0]  year_reg = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [UnixW-1:0] epoch_secs;
    logic             invalid_flag;

    t_epoch pending_epochs[$];
    int     mismatches = 0;
    int     src_gap_pct = 0;
    int     sink_stall_pct = 0;
    int     hold_seq = 0;
    int     hold_seen = 0;
    int     hold_left = 0;

    rtc_bcd_time_to_unix_seconds_top u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_seconds_reg  (seconds_reg),
        .i_minutes_reg  (minutes_reg),
        .i_hours_reg    (hours_reg),
        .i_date_reg     (date_reg),
        .i_month_reg    (month_reg),
        .i_year_reg     (year_reg),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_epoch_secs   (epoch_secs),
        .o_invalid      (invalid_flag)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int bcd_value(input logic [RegW-1:0] v);
        return int'(v[7:4]) * 10 + int'(v[3:0]);
    endfunction

    function automatic logic [RegW-1:0] to_bcd(input int n);
        return 8'(((n / 10) << 4) | (n % 10));
    endfunction

    // Calendar conversion: days-from-civil on a March-based year, then time of day.
    function automatic t_epoch rtc_to_epoch(input t_rtc_regs r);
        t_epoch      res;
        int          s, mi, h, d, mo, yr, y, era, yoe, mp, doy, doe;
        longint      days;
        logic [63:0] total;
        res.regs = r;
        s  = bcd_value(r.sec_r & 8'h7F);
        mi = bcd_value(r.min_r & 8'h7F);
        d  = bcd_value(r.date_r & 8'h3F);
        mo = bcd_value(r.month_r & 8'h1F);
        yr = 2000 + bcd_value(r.year_r) + (r.month_r[7] ? 100 : 0);
        if (r.hour_r[6]) begin
            h = bcd_value(r.hour_r & 8'h1F);
            if (h == 12)
                h = r.hour_r[5] ? 12 : 0;
            else if (r.hour_r[5])
                h = h + 12;
        end else begin
            h = bcd_value(r.hour_r & 8'h3F);
        end
        if (s > 59 || mi > 59 || h > 23 || d < 1 || d > 31 || mo < 1 || mo > 12) begin
            res.seconds = '0;
            res.invalid = 1'b1;
        end else begin
            y    = (mo <= 2) ? yr - 1 : yr;
            era  = y / 400;
            yoe  = y - era * 400;
            mp   = (mo > 2) ? mo - 3 : mo + 9;
            doy  = (153 * mp + 2) / 5 + d - 1;
            doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            days = longint'(era) * 146097 + doe - 719468;
            total = 64'(days * 86400 + h * 3600 + mi * 60 + s);
            res.seconds = total[UnixW-1:0];
            res.invalid = 1'b0;
        end
        return res;
    endfunction

    // Mostly well-formed register sets with random ignored bits, the rest raw bytes.
    function automatic t_rtc_regs random_regs();
        t_rtc_regs r;
        if ($urandom_range(99) < 25) begin
            r.sec_r   = 8'($urandom);
            r.min_r   = 8'($urandom);
            r.hour_r  = 8'($urandom);
            r.date_r  = 8'($urandom);
            r.month_r = 8'($urandom);
            r.year_r  = 8'($urandom);
        end else begin
            r.sec_r    = to_bcd($urandom_range(59));
            r.sec_r[7] = 1'($urandom_range(1));
            r.min_r    = to_bcd($urandom_range(59));
            r.min_r[7] = 1'($urandom_range(1));
            if ($urandom_range(1) == 1) begin
                r.hour_r    = to_bcd($urandom_range(12, 1));
                r.hour_r[6] = 1'b1;
                r.hour_r[5] = 1'($urandom_range(1));
            end else begin
                r.hour_r = to_bcd($urandom_range(23));
            end
            r.hour_r[7]      = 1'($urandom_range(1));
            r.date_r         = to_bcd($urandom_range(31, 1));
            r.date_r[7:6]    = 2'($urandom_range(3));
            r.month_r        = to_bcd($urandom_range(12, 1));
            r.month_r[7:5]   = 3'($urandom_range(7));
            r.year_r         = ($urandom_range(9) == 0) ? 8'($urandom)
                                                        : to_bcd($urandom_range(99));
        end
        return r;
    endfunction

    // Offer one register set, hold it until the transfer, then idle at random.
    task automatic send_regs(input t_rtc_regs r);
        in_valid    <= 1'b1;
        seconds_reg <= r.sec_r;
        minutes_reg <= r.min_r;
        hours_reg   <= r.hour_r;
        date_reg    <= r.date_r;
        month_reg   <= r.month_r;
        year_reg    <= r.year_r;
        do @(posedge clk); while (!in_ready);
        pending_epochs.push_back(rtc_to_epoch(r));
        while ($urandom_range(99) < src_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_raw(input logic [RegW-1:0] s, mi, h, d, mo, y);
        t_rtc_regs r;
        r = {s, mi, h, d, mo, y};
        send_regs(r);
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_calendar_edges();
        send_raw(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00); // first second of 2000
        send_raw(8'h59, 8'h59, 8'h23, 8'h31, 8'h92, 8'h99); // last second of 2199
        send_raw(8'hD9, 8'hD9, 8'hA3, 8'hDA, 8'hE9, 8'hFF); // ignored bits set, year 2265
        send_raw(8'h00, 8'h00, 8'h12, 8'h29, 8'h02, 8'h00); // leap day 2000
        send_raw(8'h30, 8'h45, 8'h06, 8'h31, 8'h02, 8'h01); // February 31 rolls into March
        send_raw(8'h00, 8'h00, 8'h00, 8'h29, 8'h82, 8'h00); // 2100 is not a leap year
        send_raw(8'h00, 8'h00, 8'h00, 8'h01, 8'h83, 8'h00);
        send_raw(8'h00, 8'h00, 8'h00, 8'h0F, 8'h0A, 8'h3F); // non-BCD nibbles add in
        end_burst();
    endtask

    task automatic test_twelve_hour();
        send_raw(8'h00, 8'h00, 8'h52, 8'h15, 8'h06, 8'h24); // 12 AM
        send_raw(8'h00, 8'h00, 8'h72, 8'h15, 8'h06, 8'h24); // 12 PM
        send_raw(8'h00, 8'h00, 8'h40, 8'h15, 8'h06, 8'h24); // hour 0 AM
        send_raw(8'h00, 8'h00, 8'h60, 8'h15, 8'h06, 8'h24); // hour 0 PM
        send_raw(8'h00, 8'h00, 8'h71, 8'h15, 8'h06, 8'h24);
        send_raw(8'h00, 8'h00, 8'h41, 8'h15, 8'h06, 8'h24);
        send_raw(8'h00, 8'h00, 8'hF1, 8'h15, 8'h06, 8'h24);
        send_raw(8'h00, 8'h00, 8'h73, 8'h15, 8'h06, 8'h24); // 13 PM overflows
        send_raw(8'h00, 8'h00, 8'h4F, 8'h15, 8'h06, 8'h24); // hour 15 in AM
        end_burst();
    endtask

    task automatic test_out_of_range();
        send_raw(8'h60, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00);
        send_raw(8'h00, 8'h5A, 8'h00, 8'h01, 8'h01, 8'h00);
        send_raw(8'h00, 8'h00, 8'h24, 8'h01, 8'h01, 8'h00);
        send_raw(8'h00, 8'h00, 8'h3F, 8'h01, 8'h01, 8'h00);
        send_raw(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00);
        send_raw(8'h00, 8'h00, 8'h00, 8'h32, 8'h01, 8'h00);
        send_raw(8'h00, 8'h00, 8'h00, 8'h3F, 8'h01, 8'h00);
        send_raw(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00);
        send_raw(8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h00);
        send_raw(8'h00, 8'h00, 8'h00, 8'h01, 8'h80, 8'h00);
        end_burst();
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int count);
        src_gap_pct     = src_pct;
        sink_stall_pct <= sink_pct;
        repeat (count) send_regs(random_regs());
        end_burst();
    endtask

    // Hold the output off long enough for the pipeline to fill and block the input.
    task automatic test_output_backpressure();
        src_gap_pct     = 0;
        sink_stall_pct <= 0;
        hold_seq       <= hold_seq + 1;
        repeat (40) send_regs(random_regs());
        end_burst();
    endtask

    always @(posedge clk) begin
        if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk) begin : check_results
        t_epoch want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_epochs.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("ERROR: unexpected result seconds=%0d invalid=%b",
                             epoch_secs, invalid_flag);
            end else begin
                want = pending_epochs.pop_front();
                if (epoch_secs !== want.seconds || invalid_flag !== want.invalid) begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS)
                        $display("ERROR: regs=%h seconds exp %0d got %0d, invalid exp %b got %b",
                                 want.regs, want.seconds, epoch_secs,
                                 want.invalid, invalid_flag);
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_calendar_edges();
        test_twelve_hour();
        test_out_of_range();
        test_random_traffic(0, 0, 450);
        test_random_traffic(60, 0, 450);
        test_random_traffic(0, 60, 450);
        test_random_traffic(38, 38, 450);
        test_output_backpressure();
        while (pending_epochs.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_rtc_bcd_time_to_unix_seconds_top: PASS");
        else
            $display("tb_rtc_bcd_time_to_unix_seconds_top: FAIL");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_rtc_bcd_time_to_unix_seconds_top: FAIL");
        $finish;
    end

endmodule

[sim.f]
design/rbtu_pkg.sv
design/rbtu_decode.sv
design/rbtu_days.sv
design/rtc_bcd_time_to_unix_seconds_top.sv
bench/tb_rtc_bcd_time_to_unix_seconds_top.sv
